// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== sv/dlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal length-prefix deframer package
// Request types, status codes and character constants shared by the deframer
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpd_pkg;

  // Status codes carried with every result.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NON_DIGIT  = 3'd1,
    ST_MISSING    = 3'd2,
    ST_PREMATURE  = 3'd3,
    ST_EOF_HEADER = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_e;

  // Stream characters.
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Configuration register indexes (word index within the APB space).
  localparam logic RegMaxFrameLength = 1'b0;

  // Input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_req_t;

  // Result request.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last_of_frame;
    logic [31:0] frame_length;
    status_e     status;
  } out_req_t;

endpackage

`default_nettype wire

// ===== sv/decimal_length_prefix_deframer.sv =====
// ----------------------------------------------------------------------------
// Decimal length-prefix deframer
// Splits a byte stream of "<decimal length>:<payload>" frames into payload
// bytes with a frame-last marker and reports malformed streams.
// ----------------------------------------------------------------------------
// The deframer takes one stream byte per clock and keeps that rate for as
// long as both sides keep up: each accepted byte lands in an input register,
// is decoded against the header/payload state in the next cycle, and its
// result (if any) is written into the output register once that register is
// free. The figure of one byte per clock is set by the header accumulator
// loop (length times ten plus digit, checked against the limit) and the
// payload down-counter, both of which are computed combinationally from
// their registers. A new byte is taken while a finished result still waits
// in the output register; the input stalls only when the input register
// holds a byte while the output register is full and stalled. A header
// digit or a colon that opens a payload gives no result. A zero length gives
// a single empty result marked last. Lengths above max_frame_length (and
// above LENGTH_BITS bits) are reported as too long rather than wrapping,
// and every error sends the deframer back to header phase with the header
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_length_prefix_deframer #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,

  // Stream input.
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  dlpd_pkg::in_req_t      in_data_i,

  // Result output.
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output dlpd_pkg::out_req_t     out_data_o,

  // APB configuration port.
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [2:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import dlpd_pkg::*;

  // Working width for comparing the 32-bit limit with the length cap.
  localparam int unsigned LimW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam int unsigned AccW = LENGTH_BITS + 4;

  // ------------------------------------------------------------------------
  // Configuration register.
  // ------------------------------------------------------------------------
  logic [31:0] max_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMaxFrameLength);
  assign prdata = (paddr[2] == RegMaxFrameLength) ? max_len_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      max_len_q <= pwdata;
    end
  end

  // Effective limit: the register value, capped at what the accumulator holds.
  logic [LimW-1:0]        max_len_w;
  logic [LimW-1:0]        cap_w;
  logic [LimW-1:0]        lim_w;
  logic [LENGTH_BITS-1:0] lim;

  assign max_len_w = LimW'(max_len_q);
  assign cap_w     = LimW'({LENGTH_BITS{1'b1}});
  assign lim_w     = (max_len_w < cap_w) ? max_len_w : cap_w;
  assign lim       = lim_w[LENGTH_BITS-1:0];

  // ------------------------------------------------------------------------
  // Input register.
  // ------------------------------------------------------------------------
  logic    s1_valid_q;
  in_req_t s1_data_q;
  logic    out_free;
  logic    s1_go;
  logic    in_take;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_go      = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_go) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
  end

  // ------------------------------------------------------------------------
  // Deframing state and decode.
  // ------------------------------------------------------------------------
  logic                   in_payload_q, in_payload_d;
  logic                   saw_digit_q, saw_digit_d;
  logic [LENGTH_BITS-1:0] len_acc_q, len_acc_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;

  logic [7:0]       byte_in;
  logic             eoi;
  logic             is_digit;
  logic [3:0]       digit;
  logic [AccW-1:0]  acc_next;
  logic             too_long;
  logic [LimW-1:0]  acc_w;

  logic             res_valid;
  out_req_t         res;

  assign byte_in  = s1_data_q.in_byte;
  assign eoi      = s1_data_q.end_of_input;
  assign is_digit = (byte_in >= CharZero) && (byte_in <= CharNine);
  assign digit    = 4'(byte_in - CharZero);

  // length * 10 + digit never wraps here, since the accumulator stays within
  // the limit; the comparison below is therefore exact.
  assign acc_next = AccW'({len_acc_q, 3'b000}) + AccW'({len_acc_q, 1'b0}) + AccW'(digit);
  assign too_long = acc_next > AccW'(lim);
  assign acc_w    = LimW'(len_acc_q);

  always_comb begin
    in_payload_d = in_payload_q;
    saw_digit_d  = saw_digit_q;
    len_acc_d    = len_acc_q;
    remain_d     = remain_q;
    res_valid    = 1'b0;
    res          = '{out_byte: 8'd0, has_byte: 1'b0, last_of_frame: 1'b0,
                     frame_length: 32'd0, status: ST_OK};

    priority if (in_payload_q && eoi) begin
      res_valid  = 1'b1;
      res.status = ST_PREMATURE;
    end else if (in_payload_q) begin
      res_valid    = 1'b1;
      res.out_byte = byte_in;
      res.has_byte = 1'b1;
      if (remain_q > LENGTH_BITS'(1)) begin
        remain_d = remain_q - LENGTH_BITS'(1);
      end else begin
        res.last_of_frame = 1'b1;
        res.frame_length  = acc_w[31:0];
      end
    end else if (eoi) begin
      res_valid  = 1'b1;
      res.status = ST_EOF_HEADER;
    end else if (byte_in == CharColon) begin
      if (!saw_digit_q) begin
        res_valid  = 1'b1;
        res.status = ST_MISSING;
      end else if (len_acc_q == '0) begin
        // Empty frame: a lone last marker.
        res_valid         = 1'b1;
        res.last_of_frame = 1'b1;
      end else begin
        in_payload_d = 1'b1;
        remain_d     = len_acc_q;
        saw_digit_d  = 1'b0;
      end
    end else if (is_digit) begin
      if (too_long) begin
        res_valid  = 1'b1;
        res.status = ST_TOO_LONG;
      end else begin
        len_acc_d   = acc_next[LENGTH_BITS-1:0];
        saw_digit_d = 1'b1;
      end
    end else begin
      res_valid  = 1'b1;
      res.status = ST_NON_DIGIT;
    end

    // An error or the end of a frame sends the deframer back to header phase.
    if (res_valid && ((res.status != ST_OK) || res.last_of_frame)) begin
      in_payload_d = 1'b0;
      saw_digit_d  = 1'b0;
      len_acc_d    = '0;
      remain_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      saw_digit_q  <= 1'b0;
      len_acc_q    <= '0;
      remain_q     <= '0;
    end else if (s1_go) begin
      in_payload_q <= in_payload_d;
      saw_digit_q  <= saw_digit_d;
      len_acc_q    <= len_acc_d;
      remain_q     <= remain_d;
    end
  end

  // ------------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_valid) begin
      out_data_o <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dlpd_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal length-prefix deframer checker
// Port-level assertions on the result stream, bound to the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dlpd_port_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input dlpd_pkg::out_req_t out_data_o
);

  import dlpd_pkg::*;

  logic out_held;
  logic res_err;
  logic res_blank;
  logic len_stray;
  logic byte_stray;

  assign out_held   = out_valid_o && out_stall_i;
  assign res_err    = out_valid_o && (out_data_o.status != ST_OK);
  assign res_blank  = !out_data_o.has_byte && !out_data_o.last_of_frame &&
                      (out_data_o.frame_length == 32'd0);
  assign len_stray  = out_valid_o && !out_data_o.last_of_frame &&
                      (out_data_o.frame_length != 32'd0);
  assign byte_stray = out_valid_o && !out_data_o.has_byte && (out_data_o.out_byte != 8'd0);

  // A stalled result stays offered and unchanged.
  `ASSERT_PROP(a_valid_hold, clk_i, rst_ni, out_held |=> out_valid_o, "held result withdrawn")
  `ASSERT_PROP(a_data_hold, clk_i, rst_ni, out_held |=> $stable(out_data_o), "held result changed")

  // Error results carry no byte, no last marker and no length.
  `ASSERT_PROP(a_err_clean, clk_i, rst_ni, res_err |-> res_blank, "error result carries data")

  // A frame length is only reported on the result that ends a frame.
  `ASSERT_NEVER(a_len_only_last, clk_i, rst_ni, len_stray, "length without last marker")

  // A result without a byte has a zero byte field.
  `ASSERT_NEVER(a_no_byte_zero, clk_i, rst_ni, byte_stray, "stray byte value")

endmodule

bind decimal_length_prefix_deframer dlpd_port_checker u_dlpd_checker (.*);

`default_nettype wire
